// File: src/stxdf_pkg.sv
// Shared types, codes and helpers for the STX/length/LRC frame receiver.
package stxdf_pkg;

  // Framing bytes
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Length field: number of packed BCD digits taken from the two length bytes
  localparam int unsigned LENGTH_DIGITS = 4;
  localparam logic [13:0] MAX_LEN       = 14'd9999;

  // Timeout register reset value
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Item command codes
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_OK      = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_NO_ETX  = 3'd3,
    ST_LRC     = 3'd4,
    ST_RXERR   = 3'd5
  } status_e;

  // One input item
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_item_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_slot_t;

  // One result item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        frame_end;
    logic [2:0]  status;
    logic [13:0] frame_length;
  } out_item_t;

  // Packed BCD length decode, most significant digit first, saturating
  function automatic logic [13:0] decode_length(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] field;
    logic [16:0] value;
    field = {hi, lo};
    value = '0;
    for (int i = LENGTH_DIGITS - 1; i >= 0; i--) begin
      value = (value << 3) + (value << 1) + {13'd0, field[4*i +: 4]};
    end
    if (value > {3'd0, MAX_LEN}) begin
      return MAX_LEN;
    end
    return value[13:0];
  endfunction

endpackage

// File: src/stxdf_in_if.sv
// Input channel: received bytes and time ticks.
interface stxdf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, output command, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input command, input rx_byte, input rx_error, output ready);
endinterface

// File: src/stxdf_out_if.sv
// Result channel: payload bytes and frame status.
interface stxdf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        frame_end;
  logic [2:0]  status;
  logic [13:0] frame_length;

  modport source (output valid, output data_byte, output data_valid, output frame_end,
                  output status, output frame_length, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input frame_end,
                  input status, input frame_length, output ready);
endinterface

// File: src/stxdf_cfg_if.sv
// Configuration write channel: byte timeout in ticks.
interface stxdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] wdata;

  modport source (output valid, output wdata, input ready);
  modport sink   (input valid, input wdata, output ready);
endinterface

// File: src/stx_bcd_length_lrc_deframer_core.sv
// Top level of the STX/BCD-length/LRC serial frame receiver.
//
// item_in carries one item per transfer: a UART byte (command 0, with its
// error flag) or one time tick (command 1). result_out returns exactly one
// result per item: a payload byte with data_valid, or a frame end with its
// status and decoded length, or an all-busy result. cfg_in writes the byte
// timeout in ticks; write it only while no item is in flight.
// An accepted item is held in the input register, is parsed into the result
// register, and is offered on result_out from then on. Throughput is one item
// per cycle while result_out does not stall, limited by the single frame-state
// update per item.
// Reset clears both registers' valid flags, puts the parser back to hunting
// for STX and loads the timeout with 500 ticks.
// When result_out stalls, the result register holds and the input register
// still takes one more item; item_in then drops ready until results drain.
module stx_bcd_length_lrc_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  stxdf_in_if.sink    item_in,
  stxdf_cfg_if.sink   cfg_in,
  stxdf_out_if.source result_out
);

  stxdf_pkg::in_slot_t slot;
  logic                take;
  logic [15:0]         timeout_q;

  // Timeout register, always writable
  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= stxdf_pkg::TIMEOUT_RESET;
    end else if (cfg_in.valid) begin
      timeout_q <= cfg_in.wdata;
    end
  end

  stxdf_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (item_in),
    .take_i (take),
    .slot_o (slot)
  );

  stxdf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .slot_i    (slot),
    .timeout_i (timeout_q),
    .take_o    (take),
    .out_ch    (result_out)
  );

endmodule

// File: src/stxdf_in_stage.sv
// Input register: holds one accepted item until the parser takes it.
module stxdf_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  stxdf_in_if.sink            in_ch,
  input  logic                take_i,
  output stxdf_pkg::in_slot_t slot_o
);

  logic                valid_q;
  stxdf_pkg::in_item_t item_q;
  logic                load;

  // Free when empty or when the held item leaves this cycle
  assign in_ch.ready = !valid_q || take_i;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{command: in_ch.command, rx_byte: in_ch.rx_byte, rx_error: in_ch.rx_error};
    end
  end

  assign slot_o = '{valid: valid_q, item: item_q};

endmodule

// File: src/stxdf_parser.sv
// Frame parser: phase tracking, length decode, LRC check, result register.
module stxdf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stxdf_pkg::in_slot_t slot_i,
  input  logic [15:0]         timeout_i,
  output logic                take_o,
  stxdf_out_if.source         out_ch
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_ETX,
    PH_LRC
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [13:0]          len_q, len_d;
  logic [13:0]          seen_q, seen_d;
  logic [7:0]           lrc_q, lrc_d;
  logic [15:0]          idle_q, idle_d;
  logic                 out_valid_q;
  stxdf_pkg::out_item_t res_q, res_d;

  logic                 known;
  logic                 fend;
  logic [2:0]           status;
  logic [15:0]          idle_inc;
  logic [13:0]          seen_inc;
  logic [13:0]          len_dec;
  logic [7:0]           b;

  // Advance when an item is held and the result register is free or draining
  assign take_o = slot_i.valid && (!out_valid_q || out_ch.ready);

  assign b        = slot_i.item.rx_byte;
  assign idle_inc = idle_q + 16'd1;
  assign seen_inc = seen_q + 14'd1;
  assign len_dec  = stxdf_pkg::decode_length(len_q[7:0], b);
  assign known    = (phase_q == PH_PAYLOAD) || (phase_q == PH_ETX) || (phase_q == PH_LRC);

  // Next state and result for the held item
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    lrc_d   = lrc_q;
    idle_d  = idle_q;
    fend    = 1'b0;
    status  = stxdf_pkg::ST_BUSY;
    res_d   = '0;

    if (slot_i.item.command == stxdf_pkg::CMD_TICK) begin
      if (phase_q != PH_HUNT) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_i) begin
          fend   = 1'b1;
          status = stxdf_pkg::ST_TIMEOUT;
        end
      end
    end else if (phase_q == PH_HUNT) begin
      if (!slot_i.item.rx_error && b == stxdf_pkg::STX_BYTE) begin
        phase_d = PH_LEN_HI;
        len_d   = '0;
        seen_d  = '0;
        lrc_d   = '0;
        idle_d  = '0;
      end
    end else begin
      idle_d = '0;
      if (slot_i.item.rx_error) begin
        fend   = 1'b1;
        status = stxdf_pkg::ST_RXERR;
      end else begin
        case (phase_q)
          PH_LEN_HI: begin
            len_d   = {6'd0, b};
            lrc_d   = lrc_q ^ b;
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_d   = len_dec;
            lrc_d   = lrc_q ^ b;
            seen_d  = '0;
            phase_d = (len_dec == 14'd0) ? PH_ETX : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            res_d.data_byte  = b;
            res_d.data_valid = 1'b1;
            lrc_d            = lrc_q ^ b;
            seen_d           = seen_inc;
            if (seen_inc >= len_q) begin
              phase_d = PH_ETX;
            end
          end
          PH_ETX: begin
            if (b == stxdf_pkg::ETX_BYTE) begin
              lrc_d   = lrc_q ^ b;
              phase_d = PH_LRC;
            end else begin
              fend   = 1'b1;
              status = stxdf_pkg::ST_NO_ETX;
            end
          end
          default: begin
            fend   = 1'b1;
            status = (lrc_q == b) ? stxdf_pkg::ST_OK : stxdf_pkg::ST_LRC;
          end
        endcase
      end
    end

    // Frame end: report and go back to the STX hunt
    if (fend) begin
      res_d.frame_end    = 1'b1;
      res_d.status       = status;
      res_d.frame_length = known ? len_q : 14'd0;
      phase_d            = PH_HUNT;
      len_d              = '0;
      seen_d             = '0;
      lrc_d              = '0;
      idle_d             = '0;
    end
  end

  // Frame state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      len_q       <= '0;
      seen_q      <= '0;
      lrc_q       <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (take_o) begin
        phase_q     <= phase_d;
        len_q       <= len_d;
        seen_q      <= seen_d;
        lrc_q       <= lrc_d;
        idle_q      <= idle_d;
        out_valid_q <= 1'b1;
        res_q       <= res_d;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.data_byte    = res_q.data_byte;
  assign out_ch.data_valid   = res_q.data_valid;
  assign out_ch.frame_end    = res_q.frame_end;
  assign out_ch.status       = res_q.status;
  assign out_ch.frame_length = res_q.frame_length;

endmodule

// File: sim/tb_stx_bcd_length_lrc_deframer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the STX/BCD-length/LRC frame receiver core.
module tb_stx_bcd_length_lrc_deframer_core;

  localparam int unsigned QUIET_LIMIT      = 2000;
  localparam int unsigned RECV_HOLD_CYCLES = 300;
  localparam int unsigned TRUNC_PAYLOAD    = 48;

  // Receiver phases as the testbench tracks them
  typedef enum logic [2:0] {
    RX_HUNT,
    RX_LEN_HI,
    RX_LEN_LO,
    RX_PAYLOAD,
    RX_ETX,
    RX_LRC
  } rx_phase_e;

  // Ways a generated frame is broken
  typedef enum logic [2:0] {
    FLT_NONE,
    FLT_ETX,
    FLT_LRC,
    FLT_RXERR,
    FLT_TIMEOUT
  } fault_e;

  logic clk_i;
  logic rst_ni;

  stxdf_in_if  item_if ();
  stxdf_out_if res_if ();
  stxdf_cfg_if cfg_if ();

  stx_bcd_length_lrc_deframer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (item_if),
    .cfg_in     (cfg_if),
    .result_out (res_if)
  );

  // Stimulus and expectation stores
  stxdf_pkg::in_item_t  pending_items[$];
  stxdf_pkg::out_item_t expected_results[$];

  // Predicted receiver state
  rx_phase_e   rx_phase;
  logic [7:0]  len_hi_byte;
  logic [13:0] frame_len;
  logic [13:0] payload_cnt;
  logic [7:0]  lrc_acc;
  logic [15:0] gap_ticks;
  logic [15:0] pred_timeout;

  // Run control and bookkeeping
  int          cur_timeout;
  int          idle_pct;
  logic        hold_go;
  logic        recv_hold;
  int unsigned queued_cnt;
  int unsigned items_done;
  int unsigned payload_seen;
  int unsigned settings_cnt;
  int unsigned mismatches;
  int unsigned quiet_cycles = 0;
  int unsigned frame_cnt[0:7];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Packed BCD length, most significant digit first, saturating at 9999
  function automatic logic [13:0] bcd_length(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] field;
    int          acc;
    field = {hi, lo};
    acc = 0;
    for (int d = stxdf_pkg::LENGTH_DIGITS - 1; d >= 0; d--) begin
      acc = acc * 10 + ((field >> (4 * d)) & 16'h000F);
    end
    if (acc > stxdf_pkg::MAX_LEN) begin
      return stxdf_pkg::MAX_LEN;
    end
    return 14'(acc);
  endfunction

  function automatic void clear_frame();
    rx_phase    = RX_HUNT;
    len_hi_byte = '0;
    frame_len   = '0;
    payload_cnt = '0;
    lrc_acc     = '0;
    gap_ticks   = '0;
  endfunction

  // Advance the predicted receiver by one item and return its result
  function automatic stxdf_pkg::out_item_t frame_step(stxdf_pkg::in_item_t it);
    stxdf_pkg::out_item_t r;
    logic                 had_len;
    logic                 done;
    r = '0;
    done = 1'b0;
    had_len = (rx_phase == RX_PAYLOAD) || (rx_phase == RX_ETX) || (rx_phase == RX_LRC);
    if (it.command == stxdf_pkg::CMD_TICK) begin
      if (rx_phase != RX_HUNT) begin
        gap_ticks = gap_ticks + 16'd1;
        if (gap_ticks >= pred_timeout) begin
          done = 1'b1;
          r.status = stxdf_pkg::ST_TIMEOUT;
        end
      end
    end else if (rx_phase == RX_HUNT) begin
      if (!it.rx_error && it.rx_byte == stxdf_pkg::STX_BYTE) begin
        clear_frame();
        rx_phase = RX_LEN_HI;
      end
    end else begin
      gap_ticks = '0;
      if (it.rx_error) begin
        done = 1'b1;
        r.status = stxdf_pkg::ST_RXERR;
      end else begin
        case (rx_phase)
          RX_LEN_HI: begin
            len_hi_byte = it.rx_byte;
            lrc_acc ^= it.rx_byte;
            rx_phase = RX_LEN_LO;
          end
          RX_LEN_LO: begin
            frame_len = bcd_length(len_hi_byte, it.rx_byte);
            lrc_acc ^= it.rx_byte;
            payload_cnt = '0;
            rx_phase = (frame_len == 0) ? RX_ETX : RX_PAYLOAD;
          end
          RX_PAYLOAD: begin
            r.data_byte  = it.rx_byte;
            r.data_valid = 1'b1;
            lrc_acc ^= it.rx_byte;
            payload_cnt = payload_cnt + 14'd1;
            if (payload_cnt >= frame_len) begin
              rx_phase = RX_ETX;
            end
          end
          RX_ETX: begin
            if (it.rx_byte == stxdf_pkg::ETX_BYTE) begin
              lrc_acc ^= it.rx_byte;
              rx_phase = RX_LRC;
            end else begin
              done = 1'b1;
              r.status = stxdf_pkg::ST_NO_ETX;
            end
          end
          default: begin
            done = 1'b1;
            r.status = (lrc_acc == it.rx_byte) ? stxdf_pkg::ST_OK : stxdf_pkg::ST_LRC;
          end
        endcase
      end
    end
    if (done) begin
      r.frame_end    = 1'b1;
      r.frame_length = had_len ? frame_len : 14'd0;
      clear_frame();
    end
    return r;
  endfunction

  // Item driver: one transfer per cycle at most, random gaps
  always @(posedge clk_i) begin
    stxdf_pkg::in_item_t took;
    stxdf_pkg::in_item_t nxt;
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        took.command  = item_if.command;
        took.rx_byte  = item_if.rx_byte;
        took.rx_error = item_if.rx_error;
        expected_results.push_back(frame_step(took));
        items_done++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = pending_items.pop_front();
          item_if.valid    <= 1'b1;
          item_if.command  <= nxt.command;
          item_if.rx_byte  <= nxt.rx_byte;
          item_if.rx_error <= nxt.rx_error;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    stxdf_pkg::out_item_t got;
    stxdf_pkg::out_item_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.data_byte    = res_if.data_byte;
        got.data_valid   = res_if.data_valid;
        got.frame_end    = res_if.frame_end;
        got.status       = res_if.status;
        got.frame_length = res_if.frame_length;
        if (got.frame_end) frame_cnt[got.status]++;
        if (got.data_valid) payload_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: byte %02h dv %0b end %0b st %0d len %0d",
                   $time, got.data_byte, got.data_valid, got.frame_end, got.status,
                   got.frame_length);
        end else begin
          want = expected_results.pop_front();
          if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
              got.frame_end !== want.frame_end || got.status !== want.status ||
              got.frame_length !== want.frame_length) begin
            mismatches++;
            $display("%0t: mismatch exp %02h %0b %0b %0d %0d, got %02h %0b %0b %0d %0d",
                     $time, want.data_byte, want.data_valid, want.frame_end, want.status,
                     want.frame_length, got.data_byte, got.data_valid, got.frame_end,
                     got.status, got.frame_length);
          end
        end
      end
      res_if.ready <= !recv_hold && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Long receiver hold-off, counted here once requested
  initial begin
    recv_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    recv_hold <= 1'b1;
    repeat (RECV_HOLD_CYCLES) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic put_item(logic cmd, logic [7:0] b, logic e);
    stxdf_pkg::in_item_t it;
    it.command  = cmd;
    it.rx_byte  = b;
    it.rx_error = e;
    pending_items.push_back(it);
    queued_cnt++;
  endtask

  task automatic put_byte(logic [7:0] b);
    put_item(stxdf_pkg::CMD_BYTE, b, 1'b0);
  endtask

  task automatic put_tick();
    put_item(stxdf_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Ticks between frame bytes, always short of the timeout
  task automatic put_gap();
    int most;
    most = (cur_timeout > 4) ? 3 : cur_timeout - 1;
    if (most > 0 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, most)) put_tick();
    end
  endtask

  // One frame with random payload, optionally broken
  task automatic queue_frame(logic [7:0] hi, logic [7:0] lo, fault_e flt);
    logic [7:0] seq[$];
    logic [7:0] lrc;
    logic [7:0] b;
    int         n;
    int         k;
    n = bcd_length(hi, lo);
    if ((flt == FLT_RXERR || flt == FLT_TIMEOUT) && n > TRUNC_PAYLOAD) n = TRUNC_PAYLOAD;
    seq.push_back(stxdf_pkg::STX_BYTE);
    seq.push_back(hi);
    seq.push_back(lo);
    lrc = hi ^ lo;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      seq.push_back(b);
      lrc ^= b;
    end
    seq.push_back(stxdf_pkg::ETX_BYTE);
    lrc ^= stxdf_pkg::ETX_BYTE;
    seq.push_back(lrc);
    if (flt == FLT_ETX) begin
      seq[seq.size() - 2] = stxdf_pkg::ETX_BYTE ^ 8'($urandom_range(1, 255));
    end
    if (flt == FLT_LRC) seq[seq.size() - 1] = lrc ^ 8'($urandom_range(1, 255));
    k = seq.size();
    if (flt == FLT_RXERR || flt == FLT_TIMEOUT) k = $urandom_range(1, seq.size() - 1);
    for (int i = 0; i < k; i++) begin
      if (i > 0) put_gap();
      put_byte(seq[i]);
    end
    if (flt == FLT_RXERR) begin
      put_gap();
      put_item(stxdf_pkg::CMD_BYTE, 8'($urandom_range(0, 255)), 1'b1);
    end
    if (flt == FLT_TIMEOUT) repeat (cur_timeout) put_tick();
  endtask

  // Mostly well-formed frames, some broken ones and line noise
  task automatic run_random(int n);
    int unsigned stop_at;
    int          pick;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  b;
    fault_e      flt;
    stop_at = queued_cnt + n;
    while (queued_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        case ($urandom_range(0, 3))
          0: begin
            b = 8'($urandom_range(0, 255));
            if (b == stxdf_pkg::STX_BYTE) b = ~b;
            put_item(stxdf_pkg::CMD_BYTE, b, 1'($urandom_range(0, 1)));
          end
          1: put_item(stxdf_pkg::CMD_BYTE, stxdf_pkg::STX_BYTE, 1'b1);
          2: put_tick();
          default: put_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
        endcase
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          hi = 8'h00;
          lo = 8'(16 * $urandom_range(0, 1) + $urandom_range(0, 9));
        end else if (pick < 82) begin
          hi = 8'h00;
          lo = 8'($urandom_range(0, 255));
        end else if (pick < 92) begin
          hi = 8'($urandom_range(0, 255));
          lo = 8'($urandom_range(0, 255));
        end else begin
          hi = $urandom_range(0, 1) ? 8'h99 : 8'hFF;
          lo = $urandom_range(0, 1) ? 8'h99 : 8'hFF;
        end
        pick = $urandom_range(0, 99);
        flt = (pick < 60) ? FLT_NONE : (pick < 70) ? FLT_ETX : (pick < 80) ? FLT_LRC :
              (pick < 90) ? FLT_RXERR : FLT_TIMEOUT;
        // long lengths are cut short by an abort
        if (bcd_length(hi, lo) > TRUNC_PAYLOAD && flt != FLT_RXERR && flt != FLT_TIMEOUT) begin
          flt = $urandom_range(0, 1) ? FLT_TIMEOUT : FLT_RXERR;
        end
        if (flt == FLT_TIMEOUT && cur_timeout > 16) flt = FLT_RXERR;
        queue_frame(hi, lo, flt);
      end
    end
  endtask

  // Checked at the falling edge, once the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() != 0 || expected_results.size() != 0 || item_if.valid) begin
      @(negedge clk_i);
    end
  endtask

  // Timeout register write, only with the block idle
  task automatic set_timeout(logic [15:0] v);
    wait_drained();
    cur_timeout = v;
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.wdata <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    pred_timeout = v;
    cfg_if.valid <= 1'b0;
    settings_cnt++;
  endtask

  initial begin
    int unsigned fails;
    item_if.valid    = 1'b0;
    item_if.command  = 1'b0;
    item_if.rx_byte  = '0;
    item_if.rx_error = 1'b0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.wdata     = '0;
    idle_pct         = 16;
    hold_go          = 1'b0;
    queued_cnt       = 0;
    items_done       = 0;
    payload_seen     = 0;
    settings_cnt     = 1;
    mismatches       = 0;
    foreach (frame_cnt[i]) frame_cnt[i] = 0;
    pred_timeout     = stxdf_pkg::TIMEOUT_RESET;
    cur_timeout      = stxdf_pkg::TIMEOUT_RESET;
    clear_frame();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Good frame with extreme payload bytes
    put_byte(stxdf_pkg::STX_BYTE); put_byte(8'h00); put_byte(8'h03);
    put_byte(8'h00); put_byte(8'hFF); put_byte(8'h5A);
    put_byte(stxdf_pkg::ETX_BYTE); put_byte(8'hA5);
    // Zero length goes straight to ETX; LRC is wrong
    put_byte(stxdf_pkg::STX_BYTE); put_byte(8'h00); put_byte(8'h00);
    put_byte(stxdf_pkg::ETX_BYTE); put_byte(8'hFC);
    // Hunting: stray byte, STX with receive error, tick
    put_byte(8'hFF);
    put_item(stxdf_pkg::CMD_BYTE, stxdf_pkg::STX_BYTE, 1'b1);
    put_item(stxdf_pkg::CMD_TICK, 8'h02, 1'b0);
    // All-F length saturates; frame then aborted by a receive error
    put_byte(stxdf_pkg::STX_BYTE); put_byte(8'hFF); put_byte(8'hFF);
    put_item(stxdf_pkg::CMD_BYTE, 8'hFF, 1'b1);
    // Receive error before the length is known
    put_byte(stxdf_pkg::STX_BYTE); put_item(stxdf_pkg::CMD_BYTE, 8'h00, 1'b1);
    // Wrong byte where ETX belongs
    put_byte(stxdf_pkg::STX_BYTE); put_byte(8'h00); put_byte(8'h01);
    put_byte(8'hAA); put_byte(8'h04);

    // Shortest timeout: first tick inside a frame ends it
    set_timeout(16'd1);
    put_byte(stxdf_pkg::STX_BYTE); put_tick();
    run_random(250);

    // Longest timeout
    set_timeout(16'hFFFF);
    run_random(300);

    // Stretch with no idling on either side
    set_timeout(16'd5);
    idle_pct = 0;
    run_random(300);

    // Receiver holds off while the sender keeps offering
    set_timeout(16'd3);
    idle_pct = 16;
    hold_go = 1'b1;
    run_random(300);

    set_timeout(16'($urandom_range(2, 16)));
    run_random(300);

    set_timeout(16'($urandom_range(17, 65535)));
    run_random(300);

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d items (%0d payload bytes) over %0d timeout settings.",
             items_done, payload_seen, settings_cnt);
    $display("Frames ended: ok %0d, timeout %0d, bad ETX %0d, LRC %0d, rx error %0d.",
             frame_cnt[stxdf_pkg::ST_OK], frame_cnt[stxdf_pkg::ST_TIMEOUT],
             frame_cnt[stxdf_pkg::ST_NO_ETX], frame_cnt[stxdf_pkg::ST_LRC],
             frame_cnt[stxdf_pkg::ST_RXERR]);
    fails = mismatches + expected_results.size();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
